### rtl/cpt_pkg.sv
package cpt_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PACKET_TYPE   = 3'd0;
    localparam logic [2:0] CFG_DEVICE_SUFFIX = 3'd1;
    localparam logic [2:0] CFG_MAX_ENTRIES   = 3'd2;
    localparam logic [2:0] CFG_MAX_KEY_LEN   = 3'd3;
    localparam logic [2:0] CFG_MAX_VALUE_LEN = 3'd4;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // byte classes
    localparam logic [2:0] CLS_HEADER = 3'd0;
    localparam logic [2:0] CLS_KEY    = 3'd1;
    localparam logic [2:0] CLS_VALUE  = 3'd2;
    localparam logic [2:0] CLS_TRAIL  = 3'd3;
    localparam logic [2:0] CLS_ERROR  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TYPE      = 3'd1;
    localparam logic [2:0] ERR_SUFFIX    = 3'd2;
    localparam logic [2:0] ERR_COUNT     = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;
    localparam logic [2:0] ERR_KEY_LEN   = 3'd5;
    localparam logic [2:0] ERR_VALUE_LEN = 3'd6;

    typedef struct packed {
        logic [7:0]  packet_type;
        logic [31:0] device_suffix;
        logic [7:0]  max_entries;
        logic [7:0]  max_key_len;
        logic [7:0]  max_value_len;
    } t_cfg;

    typedef struct packed {
        logic [2:0] byte_class;
        logic [7:0] out_byte;
        logic [7:0] entry_index;
        logic       entry_end;
        logic       packet_end;
        logic [2:0] error_code;
        logic [7:0] entry_count;
    } t_result;

endpackage

### rtl/config_packet_tlv_parser_unit.sv
// Configuration packet payload parser. Payload words (one byte each, signature
// already stripped, last byte flagged) are checked against the expected packet
// type and device suffix (an all-zero suffix is broadcast), then the setting
// count and the key-length/key/value-length/value records are walked. Every
// byte comes back out tagged with its class and entry index; the first
// violation is held as a sticky error code (an end inside the header reports
// truncation instead), and the verdict plus the entry count ride on the last
// byte, after which the parser is ready for the next packet. Throughput is one
// word per clock while the result channel does not stall: each word is held in
// the input register and its parse (a few compares and counter updates) runs
// between that register and the output register, which presents the result
// word. Configuration writes are taken at any time but must only be issued
// while no packet is in flight.
module config_packet_tlv_parser_unit #(
    parameter int unsigned SUFFIX_BYTES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [cpt_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cpt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input word channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_payload_last,
    // result word channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_byte_class,
    output logic [7:0]                      o_out_byte,
    output logic [7:0]                      o_entry_index,
    output logic                            o_entry_end,
    output logic                            o_packet_end,
    output logic [2:0]                      o_error_code,
    output logic [7:0]                      o_entry_count
);

    cpt_pkg::t_cfg    w_cfg;
    cpt_pkg::t_result w_res;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // result register
    logic             r_out_valid;
    cpt_pkg::t_result r_out;

    logic w_out_free;
    logic w_step;
    logic w_accept;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    cpt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    cpt_parser #(
        .SUFFIX_BYTES (SUFFIX_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_s1_valid <= i_in_valid;
            if (w_out_free) r_out_valid <= r_s1_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_payload_last;
        end
        if (w_step) r_out <= w_res;
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_class  = r_out.byte_class;
    assign o_out_byte    = r_out.out_byte;
    assign o_entry_index = r_out.entry_index;
    assign o_entry_end   = r_out.entry_end;
    assign o_packet_end  = r_out.packet_end;
    assign o_error_code  = r_out.error_code;
    assign o_entry_count = r_out.entry_count;

endmodule

### rtl/cpt_cfg_regs.sv
module cpt_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [cpt_pkg::CFG_ADDR_W-1:0]  i_addr,
    input  logic [cpt_pkg::CFG_DATA_W-1:0]  i_wdata,
    output cpt_pkg::t_cfg                   o_cfg
);

    cpt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.packet_type   <= 8'd0;
            r_cfg.device_suffix <= 32'd0;
            r_cfg.max_entries   <= 8'd8;
            r_cfg.max_key_len   <= 8'd32;
            r_cfg.max_value_len <= 8'd64;
        end else if (i_wr_en) begin
            case (i_addr)
                cpt_pkg::CFG_PACKET_TYPE:   r_cfg.packet_type   <= i_wdata[7:0];
                cpt_pkg::CFG_DEVICE_SUFFIX: r_cfg.device_suffix <= i_wdata[31:0];
                cpt_pkg::CFG_MAX_ENTRIES:   r_cfg.max_entries   <= i_wdata[7:0];
                cpt_pkg::CFG_MAX_KEY_LEN:   r_cfg.max_key_len   <= i_wdata[7:0];
                cpt_pkg::CFG_MAX_VALUE_LEN: r_cfg.max_value_len <= i_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/cpt_parser.sv
module cpt_parser #(
    parameter int unsigned SUFFIX_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  cpt_pkg::t_cfg     i_cfg,
    output cpt_pkg::t_result  o_res
);

    localparam int unsigned HPW  = $clog2(SUFFIX_BYTES + 3);
    localparam int unsigned SFXW = (SUFFIX_BYTES * 8 > 32) ? SUFFIX_BYTES * 8 : 32;

    localparam logic [HPW-1:0] HP_SFX_LAST = HPW'(SUFFIX_BYTES);
    localparam logic [HPW-1:0] HP_COUNT    = HPW'(SUFFIX_BYTES + 1);
    localparam logic [HPW-1:0] HP_SAT      = HPW'(SUFFIX_BYTES + 2);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_KEYLEN = 3'd1;
    localparam logic [2:0] PH_KEY    = 3'd2;
    localparam logic [2:0] PH_VALLEN = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;
    localparam logic [2:0] PH_ERROR  = 3'd6;

    logic [2:0]     r_phase,    n_phase;
    logic [HPW-1:0] r_hdr_pos,  n_hdr_pos;
    logic [7:0]     r_left,     n_left;
    logic [7:0]     r_total,    n_total;
    logic [7:0]     r_done,     n_done;
    logic           r_all_zero, n_all_zero;
    logic           r_match,    n_match;
    logic [2:0]     r_err,      n_err;

    logic [SFXW-1:0] w_sfx_ext;
    logic [HPW-1:0]  w_sel;
    logic [7:0]      w_want;

    assign w_sfx_ext = SFXW'(i_cfg.device_suffix);
    assign w_sel     = HP_SFX_LAST - r_hdr_pos;
    assign w_want    = 8'(w_sfx_ext >> {w_sel, 3'b000});

    always_comb begin
        logic [2:0] cls;
        logic [7:0] idx;
        logic       eend;

        cls  = cpt_pkg::CLS_HEADER;
        idx  = r_done;
        eend = 1'b0;

        n_phase    = r_phase;
        n_hdr_pos  = r_hdr_pos;
        n_left     = r_left;
        n_total    = r_total;
        n_done     = r_done;
        n_all_zero = r_all_zero;
        n_match    = r_match;
        n_err      = r_err;

        if (r_hdr_pos < HP_SAT) n_hdr_pos = r_hdr_pos + 1'b1;

        case (r_phase)
            PH_HEADER: begin
                idx = 8'd0;
                if (r_hdr_pos == '0) begin
                    if (i_byte != i_cfg.packet_type) begin
                        if (r_err == cpt_pkg::ERR_NONE) n_err = cpt_pkg::ERR_TYPE;
                        n_phase = PH_ERROR;
                    end
                end else if (r_hdr_pos <= HP_SFX_LAST) begin
                    if (i_byte != 8'd0) n_all_zero = 1'b0;
                    if (i_byte != w_want) n_match = 1'b0;
                    if (r_hdr_pos == HP_SFX_LAST && !n_all_zero && !n_match) begin
                        if (r_err == cpt_pkg::ERR_NONE) n_err = cpt_pkg::ERR_SUFFIX;
                        n_phase = PH_ERROR;
                    end
                end else begin
                    n_total = i_byte;
                    if (i_byte == 8'd0 || i_byte > i_cfg.max_entries) begin
                        if (r_err == cpt_pkg::ERR_NONE) n_err = cpt_pkg::ERR_COUNT;
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_KEYLEN;
                    end
                end
            end
            PH_KEYLEN: begin
                if (i_byte == 8'd0 || i_byte > i_cfg.max_key_len) begin
                    if (r_err == cpt_pkg::ERR_NONE) n_err = cpt_pkg::ERR_KEY_LEN;
                    n_phase = PH_ERROR;
                end else begin
                    n_left  = i_byte;
                    n_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                cls    = cpt_pkg::CLS_KEY;
                n_left = r_left - 1'b1;
                if (n_left == 8'd0) n_phase = PH_VALLEN;
            end
            PH_VALLEN: begin
                if (i_byte > i_cfg.max_value_len) begin
                    if (r_err == cpt_pkg::ERR_NONE) n_err = cpt_pkg::ERR_VALUE_LEN;
                    n_phase = PH_ERROR;
                end else if (i_byte == 8'd0) begin
                    // empty value closes the entry on its length byte
                    eend    = 1'b1;
                    n_done  = r_done + 1'b1;
                    n_phase = (n_done == r_total) ? PH_TRAIL : PH_KEYLEN;
                end else begin
                    n_left  = i_byte;
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                cls    = cpt_pkg::CLS_VALUE;
                n_left = r_left - 1'b1;
                if (n_left == 8'd0) begin
                    eend    = 1'b1;
                    n_done  = r_done + 1'b1;
                    n_phase = (n_done == r_total) ? PH_TRAIL : PH_KEYLEN;
                end
            end
            PH_TRAIL: begin
                cls = cpt_pkg::CLS_TRAIL;
                idx = 8'd0;
            end
            default: begin
                cls = cpt_pkg::CLS_ERROR;
                idx = 8'd0;
            end
        endcase

        // verdict: short header overrides, otherwise unfinished entries
        if (i_last) begin
            if (r_hdr_pos < HP_COUNT) n_err = cpt_pkg::ERR_TRUNC;
            else if (n_err == cpt_pkg::ERR_NONE && n_phase != PH_TRAIL)
                n_err = cpt_pkg::ERR_TRUNC;
        end

        o_res.byte_class  = cls;
        o_res.out_byte    = i_byte;
        o_res.entry_index = idx;
        o_res.entry_end   = eend;
        o_res.packet_end  = i_last;
        o_res.error_code  = n_err;
        o_res.entry_count = i_last ? n_total : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase    <= PH_HEADER;
            r_hdr_pos  <= '0;
            r_left     <= 8'd0;
            r_total    <= 8'd0;
            r_done     <= 8'd0;
            r_all_zero <= 1'b1;
            r_match    <= 1'b1;
            r_err      <= cpt_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hdr_pos  <= n_hdr_pos;
            r_left     <= n_left;
            r_total    <= n_total;
            r_done     <= n_done;
            r_all_zero <= n_all_zero;
            r_match    <= n_match;
            r_err      <= n_err;
        end
    end

endmodule

### sim/tb_top.sv
module tb_top;

    localparam int SUFFIX_BYTES   = 4;
    localparam int TARGET_WORDS   = 1800;  // random words to push through
    localparam int PHASE_WORDS    = 220;   // words per config / idling phase
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep; a little margin

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_KEYLEN,
        ST_KEY,
        ST_VALLEN,
        ST_VALUE,
        ST_TRAIL,
        ST_ERROR
    } t_parse_phase;

    // Predicts the tagged result word for every accepted payload word and checks
    // the result channel against it in order.
    class tlv_scoreboard;
        cpt_pkg::t_cfg    regs;
        cpt_pkg::t_result expected_words[$];
        int unsigned  failures;
        int unsigned  words_checked;
        int unsigned  verdicts[8];
        // parser state mirror
        t_parse_phase phase;
        logic [2:0]   header_pos;
        logic [7:0]   bytes_left;
        logic [7:0]   entries_total;
        logic [7:0]   entries_done;
        logic         suffix_all_zero;
        logic         suffix_matches;
        logic [2:0]   sticky_error;

        function new();
            regs.packet_type   = 8'd0;
            regs.device_suffix = 32'd0;
            regs.max_entries   = 8'd8;
            regs.max_key_len   = 8'd32;
            regs.max_value_len = 8'd64;
            failures           = 0;
            words_checked      = 0;
            foreach (verdicts[k]) verdicts[k] = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            phase           = ST_HEADER;
            header_pos      = 3'd0;
            bytes_left      = 8'd0;
            entries_total   = 8'd0;
            entries_done    = 8'd0;
            suffix_all_zero = 1'b1;
            suffix_matches  = 1'b1;
            sticky_error    = cpt_pkg::ERR_NONE;
        endfunction

        // first violation wins; parser goes dead until the end of the packet
        function void flag_violation(logic [2:0] code);
            if (sticky_error == cpt_pkg::ERR_NONE) sticky_error = code;
            phase = ST_ERROR;
        endfunction

        function void close_entry();
            entries_done = entries_done + 8'd1;
            phase = (entries_done == entries_total) ? ST_TRAIL : ST_KEYLEN;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function void note_word(logic [7:0] b, logic last_flag);
            cpt_pkg::t_result r;
            logic [2:0] hp;
            logic [7:0] want;
            int         sh;
            hp            = header_pos;
            r             = '0;
            r.byte_class  = cpt_pkg::CLS_HEADER;
            r.out_byte    = b;
            r.entry_index = entries_done;
            r.packet_end  = last_flag;
            if (hp < SUFFIX_BYTES + 2) header_pos = hp + 3'd1;
            case (phase)
                ST_HEADER: begin
                    r.entry_index = 8'd0;
                    if (hp == 0) begin
                        if (b != regs.packet_type) flag_violation(cpt_pkg::ERR_TYPE);
                    end else if (hp <= SUFFIX_BYTES) begin
                        sh   = 8 * (SUFFIX_BYTES - int'(hp));
                        want = regs.device_suffix[sh +: 8];
                        if (b != 8'd0) suffix_all_zero = 1'b0;
                        if (b != want) suffix_matches = 1'b0;
                        if (hp == SUFFIX_BYTES && !suffix_all_zero && !suffix_matches)
                            flag_violation(cpt_pkg::ERR_SUFFIX);
                    end else begin
                        entries_total = b;
                        if (b == 8'd0 || b > regs.max_entries)
                            flag_violation(cpt_pkg::ERR_COUNT);
                        else phase = ST_KEYLEN;
                    end
                end
                ST_KEYLEN: begin
                    if (b == 8'd0 || b > regs.max_key_len) begin
                        flag_violation(cpt_pkg::ERR_KEY_LEN);
                    end else begin
                        bytes_left = b;
                        phase      = ST_KEY;
                    end
                end
                ST_KEY: begin
                    r.byte_class = cpt_pkg::CLS_KEY;
                    bytes_left   = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) phase = ST_VALLEN;
                end
                ST_VALLEN: begin
                    if (b > regs.max_value_len) begin
                        flag_violation(cpt_pkg::ERR_VALUE_LEN);
                    end else if (b == 8'd0) begin
                        close_entry();
                        r.entry_end = 1'b1;
                    end else begin
                        bytes_left = b;
                        phase      = ST_VALUE;
                    end
                end
                ST_VALUE: begin
                    r.byte_class = cpt_pkg::CLS_VALUE;
                    bytes_left   = bytes_left - 8'd1;
                    if (bytes_left == 8'd0) begin
                        close_entry();
                        r.entry_end = 1'b1;
                    end
                end
                ST_TRAIL: begin
                    r.byte_class  = cpt_pkg::CLS_TRAIL;
                    r.entry_index = 8'd0;
                end
                default: begin
                    r.byte_class  = cpt_pkg::CLS_ERROR;
                    r.entry_index = 8'd0;
                end
            endcase
            // a short header is always truncated; otherwise only an unfinished clean packet
            if (last_flag) begin
                if (hp < SUFFIX_BYTES + 1)
                    sticky_error = cpt_pkg::ERR_TRUNC;
                else if (sticky_error == cpt_pkg::ERR_NONE && phase != ST_TRAIL)
                    sticky_error = cpt_pkg::ERR_TRUNC;
            end
            r.error_code  = sticky_error;
            r.entry_count = last_flag ? entries_total : 8'd0;
            expected_words.push_back(r);
            if (last_flag) begin
                verdicts[sticky_error]++;
                clear_packet();
            end
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                failures++;
            end
        endfunction

        function void check_word(cpt_pkg::t_result act);
            cpt_pkg::t_result exp_w;
            if (expected_words.size() == 0) begin
                $error("result word with nothing pending (out_byte %0d)", act.out_byte);
                failures++;
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                compare_field("byte_class",  exp_w.byte_class,  act.byte_class);
                compare_field("out_byte",    exp_w.out_byte,    act.out_byte);
                compare_field("entry_index", exp_w.entry_index, act.entry_index);
                compare_field("entry_end",   exp_w.entry_end,   act.entry_end);
                compare_field("packet_end",  exp_w.packet_end,  act.packet_end);
                compare_field("error_code",  exp_w.error_code,  act.error_code);
                compare_field("entry_count", exp_w.entry_count, act.entry_count);
            end
        endfunction
    endclass

    // DUT hookup; every input starts known
    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_wr_en    = 1'b0;
    logic [cpt_pkg::CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [cpt_pkg::CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                           i_in_valid     = 1'b0;
    logic [7:0]                     i_data_byte    = 8'd0;
    logic                           i_payload_last = 1'b0;
    logic                           i_out_stall    = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [2:0]                     o_byte_class;
    logic [7:0]                     o_out_byte;
    logic [7:0]                     o_entry_index;
    logic                           o_entry_end;
    logic                           o_packet_end;
    logic [2:0]                     o_error_code;
    logic [7:0]                     o_entry_count;

    config_packet_tlv_parser_unit #(
        .SUFFIX_BYTES(SUFFIX_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_payload_last (i_payload_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_class   (o_byte_class),
        .o_out_byte     (o_out_byte),
        .o_entry_index  (o_entry_index),
        .o_entry_end    (o_entry_end),
        .o_packet_end   (o_packet_end),
        .o_error_code   (o_error_code),
        .o_entry_count  (o_entry_count)
    );

    tlv_scoreboard sb = new();

    int          send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int          recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int unsigned words_sent     = 0;
    int unsigned packets_sent   = 0;
    int unsigned phases_run     = 0;
    int          idle_cycles    = 0;
    logic [7:0]  pkt_bytes[$];         // packet under construction

    always #10 i_clk = ~i_clk;

    // Receiver side: random stall, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: everything is sampled at the edge, before any NBA lands, so
    // the values seen here are the ones the DUT saw at this edge.
    always @(posedge i_clk) begin
        cpt_pkg::t_result seen;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_word(i_data_byte, i_payload_last);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                seen.byte_class  = o_byte_class;
                seen.out_byte    = o_out_byte;
                seen.entry_index = o_entry_index;
                seen.entry_end   = o_entry_end;
                seen.packet_end  = o_packet_end;
                seen.error_code  = o_error_code;
                seen.entry_count = o_entry_count;
                sb.check_word(seen);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: nothing moved for too long -> hung.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_top: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // One payload word, with an optional random hold-off in front. Valid stays
    // up and the payload stays put until the word is taken.
    task automatic send_word(input logic [7:0] b, input logic last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_payload_last <= last_flag;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic send_packet();
        int j;
        for (j = 0; j < pkt_bytes.size(); j++)
            send_word(pkt_bytes[j], j == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    // Sender goes quiet until every predicted word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Only called with the block idle. Writes all five registers in turn.
    task automatic write_config(input cpt_pkg::t_cfg c);
        int i;
        i_cfg_wr_en <= 1'b1;
        for (i = 0; i < 5; i++) begin
            case (i)
                0: begin
                    i_cfg_addr  <= cpt_pkg::CFG_PACKET_TYPE;
                    i_cfg_wdata <= cpt_pkg::CFG_DATA_W'(c.packet_type);
                end
                1: begin
                    i_cfg_addr  <= cpt_pkg::CFG_DEVICE_SUFFIX;
                    i_cfg_wdata <= cpt_pkg::CFG_DATA_W'(c.device_suffix);
                end
                2: begin
                    i_cfg_addr  <= cpt_pkg::CFG_MAX_ENTRIES;
                    i_cfg_wdata <= cpt_pkg::CFG_DATA_W'(c.max_entries);
                end
                3: begin
                    i_cfg_addr  <= cpt_pkg::CFG_MAX_KEY_LEN;
                    i_cfg_wdata <= cpt_pkg::CFG_DATA_W'(c.max_key_len);
                end
                default: begin
                    i_cfg_addr  <= cpt_pkg::CFG_MAX_VALUE_LEN;
                    i_cfg_wdata <= cpt_pkg::CFG_DATA_W'(c.max_value_len);
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        sb.regs = c;
    endtask

    // Settings per phase: a typical one, all-max, all-min, then random.
    function automatic cpt_pkg::t_cfg pick_config(int ph);
        cpt_pkg::t_cfg c;
        case (ph)
            0: begin
                c.packet_type   = 8'd70;
                c.device_suffix = 32'h1234_5678;
                c.max_entries   = 8'd8;
                c.max_key_len   = 8'd32;
                c.max_value_len = 8'd64;
            end
            1: begin
                c.packet_type   = 8'hFF;
                c.device_suffix = 32'hFFFF_FFFF;
                c.max_entries   = 8'hFF;
                c.max_key_len   = 8'hFF;
                c.max_value_len = 8'hFF;
            end
            2: begin
                c.packet_type   = 8'h00;
                c.device_suffix = 32'h0000_0000;
                c.max_entries   = 8'd1;
                c.max_key_len   = 8'd1;
                c.max_value_len = 8'd0;
            end
            default: begin
                c.packet_type   = 8'($urandom);
                c.device_suffix = ($urandom_range(99) < 25) ? 32'd0 : 32'($urandom);
                c.max_entries   = 8'($urandom_range(12, 1));
                c.max_key_len   = 8'($urandom_range(10, 1));
                c.max_value_len = 8'($urandom_range(10, 0));
            end
        endcase
        return c;
    endfunction

    // Mostly well-formed packets with random content. Some get a wrong type,
    // a foreign suffix, a bad count or a bad length; some are cut short, some
    // carry trailing junk, a few are plain noise.
    task automatic build_packet();
        int unsigned roll, count, klen, vlen, cap, e, i;
        int          err_at;
        bit          tiny;
        pkt_bytes.delete();
        err_at = -1;
        tiny   = 1'b0;
        roll   = $urandom_range(99);
        if (roll < 5) begin
            repeat ($urandom_range(12, 1)) pkt_bytes.push_back(8'($urandom));
        end else begin
            pkt_bytes.push_back(($urandom_range(99) < 92) ? sb.regs.packet_type
                                                          : 8'($urandom));
            // suffix: broadcast, ours, or someone else's
            roll = $urandom_range(99);
            for (i = 0; i < SUFFIX_BYTES; i++) begin
                if (roll < 30)
                    pkt_bytes.push_back(8'h00);
                else if (roll < 88)
                    pkt_bytes.push_back(sb.regs.device_suffix[8*(SUFFIX_BYTES-1-i) +: 8]);
                else
                    pkt_bytes.push_back(8'($urandom));
            end
            roll = $urandom_range(99);
            cap  = (sb.regs.max_entries < 4) ? sb.regs.max_entries : 4;
            if (roll < 3) begin
                count = 0;
            end else if (roll < 6 && sb.regs.max_entries < 255) begin
                count = $urandom_range(255, sb.regs.max_entries + 1);
            end else if (roll < 8) begin
                // full count, minimal records, to run the entry index to its top
                count = sb.regs.max_entries;
                tiny  = 1'b1;
            end else begin
                count = $urandom_range(cap, 1);
            end
            pkt_bytes.push_back(8'(count));
            if (count == 0 || count > sb.regs.max_entries) err_at = pkt_bytes.size() - 1;
            for (e = 0; e < count && err_at < 0; e++) begin
                roll = $urandom_range(99);
                cap  = (sb.regs.max_key_len < 6) ? sb.regs.max_key_len : 6;
                if (tiny)
                    klen = 1;
                else if (roll < 3)
                    klen = 0;
                else if (roll < 5 && sb.regs.max_key_len < 255)
                    klen = $urandom_range(255, sb.regs.max_key_len + 1);
                else if (roll < 7)
                    klen = sb.regs.max_key_len;
                else
                    klen = $urandom_range(cap, 1);
                pkt_bytes.push_back(8'(klen));
                if (klen == 0 || klen > sb.regs.max_key_len) begin
                    err_at = pkt_bytes.size() - 1;
                end else begin
                    repeat (klen) pkt_bytes.push_back(8'($urandom));
                    roll = $urandom_range(99);
                    cap  = (sb.regs.max_value_len < 6) ? sb.regs.max_value_len : 6;
                    if (tiny)
                        vlen = 0;
                    else if (roll < 3 && sb.regs.max_value_len < 255)
                        vlen = $urandom_range(255, sb.regs.max_value_len + 1);
                    else if (roll < 5)
                        vlen = sb.regs.max_value_len;
                    else
                        vlen = $urandom_range(cap, 0);
                    pkt_bytes.push_back(8'(vlen));
                    if (vlen > sb.regs.max_value_len) err_at = pkt_bytes.size() - 1;
                    else repeat (vlen) pkt_bytes.push_back(8'($urandom));
                end
            end
            // end right on the bad byte half the time, else some dead bytes after it
            if (err_at >= 0 && $urandom_range(1) == 0) begin
                // nothing follows
            end else if (err_at >= 0 || $urandom_range(99) < 30) begin
                repeat ($urandom_range(3, 1)) pkt_bytes.push_back(8'($urandom));
            end
            // cut anywhere, header included
            if ($urandom_range(99) < 12) begin
                cap = $urandom_range(pkt_bytes.size(), 1);
                while (pkt_bytes.size() > cap) void'(pkt_bytes.pop_back());
            end
        end
    endtask

    initial begin
        int          ph;
        int unsigned phase_start;
        int unsigned pkt_no;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on reset settings (type 0, broadcast, limits 8/32/64).
        // clean packet: empty value closes the entry on its length word, then a trailing word
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h41, 8'h00, 8'hFF};
        send_packet();
        // wrong type, then the packet ends inside the header: truncation overrides
        pkt_bytes = '{8'h2A, 8'h00};
        send_packet();
        // count above the limit, ending on the count word
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09};
        send_packet();
        // ends in the middle of a key
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h41};
        send_packet();

        // Random phases, each with its own settings and idling pattern.
        ph = 0;
        while (words_sent < TARGET_WORDS) begin
            drain_results();
            repeat (4) @(posedge i_clk);
            write_config(pick_config(ph));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_start = words_sent;
            pkt_no      = 0;
            while (words_sent - phase_start < PHASE_WORDS) begin
                // now and then let the pipe run dry before the next packet
                if (pkt_no % 8 == 7) drain_results();
                build_packet();
                send_packet();
                pkt_no++;
            end
            ph++;
            phases_run++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d result words never arrived", sb.pending());
            sb.failures++;
        end

        $display("tb_top: %0d words in %0d packets over %0d setting phases, %0d results checked",
                 words_sent, packets_sent, phases_run, sb.words_checked);
        $display("tb_top: verdicts ok %0d type %0d suffix %0d count %0d trunc %0d key %0d value %0d",
                 sb.verdicts[cpt_pkg::ERR_NONE], sb.verdicts[cpt_pkg::ERR_TYPE],
                 sb.verdicts[cpt_pkg::ERR_SUFFIX], sb.verdicts[cpt_pkg::ERR_COUNT],
                 sb.verdicts[cpt_pkg::ERR_TRUNC], sb.verdicts[cpt_pkg::ERR_KEY_LEN],
                 sb.verdicts[cpt_pkg::ERR_VALUE_LEN]);
        if (sb.failures == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
